// ----- hdl/frps_pkg.sv -----
// Package with types and constants of the fixed-radius pair search.
`default_nettype none
package frps_pkg;
	localparam int MaxPointsDef = 64;
	localparam int MaxDimsDef = 16;
	localparam int AccW = 36;
	localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};
	localparam logic [0:0] RegDims = 1'b0;
	localparam logic [0:0] RegRadius = 1'b1;

	typedef struct packed {
		logic signed [15:0] coordinate;
		logic new_set;
	} in_item_t;

	typedef struct packed {
		logic [5:0] earlier_index;
		logic [5:0] new_index;
		logic [AccW-1:0] squared_distance;
		logic last_pair;
	} out_item_t;
endpackage
`default_nettype wire

// ----- hdl/fixed_radius_pair_search.sv -----
// Top level of the fixed-radius pair search over a stream of points.
//
// Usage: coordinates of each point enter one per beat on start/item, in
// dimension order; the block is busy while it works on one. Each stored point
// keeps its squared distance to the arriving point in an accumulator memory.
// A coordinate walks all stored points, one per cycle: one store read, one
// multiply, one accumulator read-modify-write; busy stays high until the
// walk has drained, and the next coordinate is taken after that.
// On the last coordinate a second walk over the accumulators emits every
// qualifying pair, at most one per cycle on result_valid with result, in
// rising earlier index; busy stays high until that walk has drained too.
// With no stored point a coordinate is stored without a walk. Results
// cannot be held off; each is shown for one cycle. Configuration writes
// (cfg_we, cfg_index, cfg_data) take effect at once and are to be made
// while the block is idle; the block itself does not enforce this.
// Reset empties the point set and the accumulators through valid bits;
// the point store itself is not cleared. When the store is full, further
// points are dropped until new_set.
`default_nettype none
module fixed_radius_pair_search #(
	parameter int MAX_POINTS = frps_pkg::MaxPointsDef,
	parameter int MAX_DIMS = frps_pkg::MaxDimsDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire frps_pkg::in_item_t item,
	output logic busy,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [frps_pkg::AccW-1:0] cfg_data,
	output logic result_valid,
	output frps_pkg::out_item_t result
);
	import frps_pkg::*;

	localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [2:0] {IDLE, ACC, ACC_TAIL, EMIT, EMIT_TAIL} state_t;

	state_t state_q;
	logic [4:0] dims_q;
	logic [AccW-1:0] radius_q;
	logic [CW-1:0] count_q;
	logic [DW-1:0] pos_q;
	logic signed [15:0] coord_q;
	logic [PW-1:0] idx_q;
	logic last_q;

	logic [15:0] store_mem [2**(PW+DW)];
	logic [AccW-1:0] acc_mem [MAX_POINTS];
	logic [MAX_POINTS-1:0] acc_vld_q;

	logic [15:0] store_rd_s1;
	logic [AccW-1:0] acc_rd_s1;
	logic rd_vld_s1;
	logic [PW-1:0] idx_s1;
	logic [AccW-1:0] sq_s2;
	logic [AccW-1:0] acc_s2;
	logic acc_vld_s2;
	logic rd_vld_s2;
	logic [PW-1:0] idx_s2;

	logic [DW:0] eff_dims;
	logic [DW-1:0] pos_eff;
	logic signed [16:0] diff;
	logic [16:0] adiff;
	logic [33:0] sq;
	logic [AccW:0] sum;
	logic [AccW-1:0] sum_sat;
	logic [AccW-1:0] acc_cur;
	logic rd_en;
	logic found_q;
	logic [PW-1:0] pend_idx_q;
	logic [AccW-1:0] pend_dist_q;

	always_comb begin
		if (dims_q == 5'd0) eff_dims = (DW+1)'(1);
		else if (32'(dims_q) > MAX_DIMS) eff_dims = (DW+1)'(MAX_DIMS);
		else eff_dims = (DW+1)'(dims_q);
		pos_eff = pos_q;
		diff = 17'(coord_q) - 17'(signed'(store_rd_s1));
		adiff = diff[16] ? 17'(-diff) : diff;
		sq = adiff * adiff;
		acc_cur = acc_vld_s2 ? acc_s2 : '0;
		sum = {1'b0, acc_cur} + {1'b0, sq_s2};
		sum_sat = sum[AccW] ? AccMax : sum[AccW-1:0];
		rd_en = (state_q == ACC || state_q == EMIT);
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			store_rd_s1 <= store_mem[{idx_q, pos_eff}];
			acc_rd_s1 <= acc_mem[idx_q];
		end
		if (state_q == IDLE && start && count_q < CW'(MAX_POINTS) && !item.new_set)
			store_mem[{count_q[PW-1:0], pos_q}] <= item.coordinate;
		else if (state_q == IDLE && start && item.new_set)
			store_mem[{{PW{1'b0}}, {DW{1'b0}}}] <= item.coordinate;
		sq_s2 <= AccW'(sq);
		acc_s2 <= acc_rd_s1;
		idx_s2 <= idx_s1;
		if (rd_vld_s2 && state_q != EMIT && state_q != EMIT_TAIL)
			acc_mem[idx_s2] <= sum_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			dims_q <= 5'd3;
			radius_q <= '0;
			count_q <= '0;
			pos_q <= '0;
			coord_q <= '0;
			idx_q <= '0;
			last_q <= 1'b0;
			acc_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_vld_s2 <= 1'b0;
			idx_s1 <= '0;
			acc_vld_s2 <= 1'b0;
			found_q <= 1'b0;
			pend_idx_q <= '0;
			pend_dist_q <= '0;
			result_valid <= 1'b0;
			result <= '0;
		end else begin
			result_valid <= 1'b0;
			rd_vld_s1 <= rd_en;
			idx_s1 <= idx_q;
			rd_vld_s2 <= rd_vld_s1;
			acc_vld_s2 <= acc_vld_q[idx_s1];
			if (cfg_we) begin
				if (cfg_index == RegDims) dims_q <= cfg_data[4:0];
				else dims_q <= dims_q;
				if (cfg_index == RegRadius) radius_q <= cfg_data;
			end
			if (rd_vld_s2 && state_q != EMIT && state_q != EMIT_TAIL)
				acc_vld_q[idx_s2] <= 1'b1;
			case (state_q)
				IDLE: begin
					if (start) begin
						logic [CW-1:0] cnt;
						logic [DW-1:0] p;
						cnt = item.new_set ? '0 : count_q;
						p = item.new_set ? '0 : pos_q;
						if (item.new_set) begin
							count_q <= '0;
							pos_q <= '0;
							acc_vld_q <= '0;
						end
						if (cnt < CW'(MAX_POINTS)) begin
							coord_q <= item.coordinate;
							pos_q <= p;
							last_q <= (32'(p) + 1 >= 32'(eff_dims));
							idx_q <= '0;
							if (cnt != '0) state_q <= ACC;
							else if (32'(p) + 1 >= 32'(eff_dims)) begin
								count_q <= cnt + CW'(1);
								pos_q <= '0;
								acc_vld_q <= '0;
							end else pos_q <= p + DW'(1);
						end
					end
				end
				ACC: begin
					if (32'(idx_q) + 1 >= 32'(count_q)) state_q <= ACC_TAIL;
					else idx_q <= idx_q + PW'(1);
				end
				ACC_TAIL: begin
					if (!rd_vld_s1 && !rd_vld_s2 && !rd_en) begin
						if (last_q) begin
							idx_q <= '0;
							found_q <= 1'b0;
							state_q <= EMIT;
						end else begin
							pos_q <= pos_q + DW'(1);
							state_q <= IDLE;
						end
					end
				end
				EMIT: begin
					if (32'(idx_q) + 1 >= 32'(count_q)) state_q <= EMIT_TAIL;
					else idx_q <= idx_q + PW'(1);
				end
				default: begin
					if (!rd_vld_s1 && !rd_vld_s2) begin
						if (found_q) begin
							result_valid <= 1'b1;
							result.earlier_index <= 6'(pend_idx_q);
							result.new_index <= 6'(count_q);
							result.squared_distance <= pend_dist_q;
							result.last_pair <= 1'b1;
						end
						count_q <= count_q + CW'(1);
						pos_q <= '0;
						acc_vld_q <= '0;
						found_q <= 1'b0;
						state_q <= IDLE;
					end
				end
			endcase
			if ((state_q == EMIT || state_q == EMIT_TAIL) && rd_vld_s2
					&& (acc_vld_s2 ? acc_s2 : '0) < radius_q) begin
				if (found_q) begin
					result_valid <= 1'b1;
					result.earlier_index <= 6'(pend_idx_q);
					result.new_index <= 6'(count_q);
					result.squared_distance <= pend_dist_q;
					result.last_pair <= 1'b0;
				end
				found_q <= 1'b1;
				pend_idx_q <= idx_s2;
				pend_dist_q <= acc_vld_s2 ? acc_s2 : '0;
			end
		end
	end

	assign busy = (state_q != IDLE);
endmodule
`default_nettype wire
